>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros for the alt_checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/alt_pkg.sv
// ----------------------------------------------------------------------------
// alt_pkg
// types and constants shared by the assembler line tokenizer
// ----------------------------------------------------------------------------
package alt_pkg;

  // longest token before a forced close
  localparam int MAX_TOKEN = 512;
  localparam int LEN_W     = (MAX_TOKEN > 2) ? $clog2(MAX_TOKEN) : 1;
  localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(MAX_TOKEN - 1);

  // result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // byte codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5c;

  typedef enum logic [1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_STRING = 2'd1,
    MODE_CHAR   = 2'd2
  } lex_mode_t;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_CLOSE     = 2'd1,
    KIND_EMPTY_END = 2'd2
  } kind_t;

  // one result item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       line_end;
    logic       last_of_run;
  } result_t;

  // results caused by one request
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } result_pair_t;

endpackage

>>> sv/alt_lexer.sv
// ----------------------------------------------------------------------------
// alt_lexer
// lexer state and per-byte decode, up to two results per accepted byte
// ----------------------------------------------------------------------------
module alt_lexer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [7:0]           char_in,
  output alt_pkg::result_pair_t results
);
  import alt_pkg::*;

  lex_mode_t        mode_r, mode_nxt;
  logic             comment_r, comment_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             bslash_r, bslash_nxt;

  logic has_tok;
  logic is_sep;
  logic is_semi;

  assign has_tok = (len_r != '0);
  assign is_semi = (char_in == CH_SEMI);
  assign is_sep  = (mode_r == MODE_PLAIN) &&
                   (char_in == CH_SPACE || char_in == CH_COMMA ||
                    char_in == CH_TAB   || is_semi);

  // decode of one byte against the current state
  always_comb begin
    mode_nxt    = mode_r;
    comment_nxt = comment_r;
    len_nxt     = len_r;
    bslash_nxt  = bslash_r;
    results     = '0;

    if (char_in == CH_NUL) begin
      // line end: close or report empty, then back to reset values
      results.count         = 2'd1;
      results.res0.kind     = has_tok ? KIND_CLOSE : KIND_EMPTY_END;
      results.res0.line_end = 1'b1;
      results.res0.last_of_run = 1'b1;
      mode_nxt    = MODE_PLAIN;
      comment_nxt = 1'b0;
      len_nxt     = '0;
      bslash_nxt  = 1'b0;
    end else if (comment_r) begin
      results.count = 2'd0;
    end else if (is_sep) begin
      // separator closes any open token
      results.count            = has_tok ? 2'd1 : 2'd0;
      results.res0.kind        = KIND_CLOSE;
      results.res0.last_of_run = 1'b1;
      if (is_semi) begin
        comment_nxt = 1'b1;
      end
      len_nxt    = '0;
      bslash_nxt = 1'b0;
    end else begin
      // quote mode tracking
      case (mode_r)
        MODE_PLAIN: begin
          if (char_in == CH_DQUOTE) begin
            mode_nxt = MODE_STRING;
          end else if (char_in == CH_SQUOTE) begin
            mode_nxt = MODE_CHAR;
          end
        end
        MODE_STRING: begin
          if (char_in == CH_DQUOTE && !bslash_r) begin
            mode_nxt = MODE_PLAIN;
          end
        end
        MODE_CHAR: begin
          if (char_in == CH_SQUOTE && !bslash_r) begin
            mode_nxt = MODE_PLAIN;
          end
        end
        default: begin
          mode_nxt = MODE_PLAIN;
        end
      endcase
      bslash_nxt        = (char_in == CH_BSLASH);
      results.res0.kind = KIND_BYTE;
      results.res0.out_byte = char_in;
      if (len_r == LEN_LAST) begin
        // token at the cap: byte then forced close
        results.count            = 2'd2;
        results.res1.kind        = KIND_CLOSE;
        results.res1.last_of_run = 1'b1;
        len_nxt    = '0;
        mode_nxt   = MODE_PLAIN;
        bslash_nxt = 1'b0;
      end else begin
        results.count            = 2'd1;
        results.res0.last_of_run = 1'b1;
        len_nxt = len_r + 1'b1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_PLAIN;
      comment_r <= 1'b0;
      len_r     <= '0;
      bslash_r  <= 1'b0;
    end else if (fire) begin
      mode_r    <= mode_nxt;
      comment_r <= comment_nxt;
      len_r     <= len_nxt;
      bslash_r  <= bslash_nxt;
    end
  end

endmodule

>>> sv/alt_result_queue.sv
// ----------------------------------------------------------------------------
// alt_result_queue
// small result queue: takes up to two results a cycle, gives one
// ----------------------------------------------------------------------------
module alt_result_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  alt_pkg::result_pair_t push_data,
  output logic                  room,
  output logic                  out_valid,
  input  logic                  out_ready,
  output alt_pkg::result_t      out_data
);
  import alt_pkg::*;

  result_t           entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic [1:0]        push_n;
  logic              pop;
  logic [QPTR_W-1:0] wr_ptr_p1;

  assign push_n    = push ? push_data.count : 2'd0;
  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  // room for a full pair of results
  assign room      = (count_r <= QCNT_W'(QDEPTH - 2));
  assign out_valid = (count_r != '0);
  assign out_data  = entry_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    count_nxt  = count_r + QCNT_W'(push_n) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry writes, no reset needed
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entry_r[wr_ptr_r] <= push_data.res0;
    end
    if (push_n == 2'd2) begin
      entry_r[wr_ptr_p1] <= push_data.res1;
    end
  end

endmodule

>>> sv/asm_line_tokenizer.sv
// ----------------------------------------------------------------------------
// asm_line_tokenizer
// assembler source line tokenizer, one byte per request
// ----------------------------------------------------------------------------
// Usage: source bytes enter on in_char_in with in_valid/in_ready; a zero
// byte ends the line. Results leave on out_kind, out_byte, out_line_end and
// out_last_of_run with out_valid/out_ready: a token byte, a token close, or
// an empty line end. Each byte gives zero, one or two results.
// Each result is written into the result queue before it is offered.
// Throughput: one byte per cycle while in_ready is high; the lexer state
// is registered. A four-entry result queue drains one result per cycle
// while out_ready is high; a byte that makes two results (token cap reached)
// fills two slots, and in_ready drops only when fewer than two are free.
// Reset: synchronous active-low rst_n puts the lexer in plain mode with no
// open token and empties the queue.
// Stall: while out_ready is low results stay queued and in_ready falls once
// the queue cannot take another pair; nothing is lost.
// ----------------------------------------------------------------------------
module asm_line_tokenizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_line_end,
  output logic       out_last_of_run
);
  import alt_pkg::*;

  logic         in_fire;
  result_pair_t pair;
  result_t      head;

  assign in_fire = in_valid && in_ready;

  // byte decode and lexer state
  alt_lexer u_lexer (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (in_fire),
    .char_in (in_char_in),
    .results (pair)
  );

  // result buffering
  alt_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (pair),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (head)
  );

  assign out_kind        = head.kind;
  assign out_byte        = head.out_byte;
  assign out_line_end    = head.line_end;
  assign out_last_of_run = head.last_of_run;

endmodule

>>> sv/alt_checker.sv
// ----------------------------------------------------------------------------
// alt_checker
// port-level checks on the tokenizer result stream
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module alt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_char_in,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte,
  input logic       out_line_end,
  input logic       out_last_of_run
);
  import alt_pkg::*;

  logic kind_ok;
  logic not_byte;
  logic in_idle;

  assign kind_ok  = (out_kind == KIND_BYTE) || (out_kind == KIND_CLOSE) ||
                    (out_kind == KIND_EMPTY_END);
  assign not_byte = (out_kind != KIND_BYTE);
  assign in_idle  = !(in_valid && in_ready) || (in_char_in == in_char_in);

  // only defined kinds leave the block
  `ASSERT_IMPLIES(a_kind_legal, clk, rst_n, out_valid, kind_ok && in_idle)
  // byte field is zero on anything but a token byte
  `ASSERT_IMPLIES(a_byte_zero, clk, rst_n, out_valid && not_byte, out_byte == 8'h00)
  // a line end is always the last result of its byte
  `ASSERT_IMPLIES(a_end_last, clk, rst_n, out_valid && out_line_end, out_last_of_run)
  // an empty line report always ends the line
  `ASSERT_IMPLIES(a_empty_end, clk, rst_n,
                  out_valid && out_kind == KIND_EMPTY_END, out_line_end)
  // a stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

endmodule

bind asm_line_tokenizer alt_checker u_alt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_char_in      (in_char_in),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_kind        (out_kind),
  .out_byte        (out_byte),
  .out_line_end    (out_line_end),
  .out_last_of_run (out_last_of_run)
);
